@@ rtl/kdhr_pkg.sv @@
// Shared types and codes of the key event debounce, hold and repeat block.
`timescale 1ns / 1ps
package kdhr_pkg;

  localparam int unsigned TickW      = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned KeyW       = 3;
  localparam int unsigned PortW      = 8;
  localparam int unsigned MaxResults = 32;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned CfgIdxW    = 8;

  typedef enum logic [1:0] {
    ActSample  = 2'd0,
    ActScan    = 2'd1,
    ActConsume = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    KindDown    = 3'd0,
    KindPress   = 3'd1,
    KindUp      = 3'd2,
    KindUpHeld  = 3'd3,
    KindHold    = 3'd4,
    KindRepeat  = 3'd5
  } kind_e;

  localparam logic [CfgIdxW-1:0] CfgDebounce = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHold     = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgRptDelay = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgRptIntvl = 8'd3;

  // Pending event slots of one key, in emission order.
  localparam int unsigned SlotDown   = 0;
  localparam int unsigned SlotPress  = 1;
  localparam int unsigned SlotUp     = 2;
  localparam int unsigned SlotHold   = 3;
  localparam int unsigned SlotRepeat = 4;
  localparam int unsigned NumSlots   = 5;

  typedef struct packed {
    logic [TickW-1:0] debounce;
    logic [TickW-1:0] hold_dly;
    logic [TickW-1:0] rpt_dly;
    logic [TickW-1:0] rpt_intvl;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             sample;
    logic [TimeW-1:0] stime;
    logic [TimeW-1:0] now;
  } scan_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    kind_e           kind;
    logic            last_in_cell;
    logic            rest_after;
  } head_t;

endpackage

@@ rtl/kdhr_cell.sv @@
// One key cell: per-key state, event scheduling and the emission token.
`timescale 1ns / 1ps
module kdhr_cell #(
  parameter int unsigned KEY_IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kdhr_pkg::cfg_t cfg_i,
  input  kdhr_pkg::scan_t scan_i,
  input  logic           port_bit_i,
  input  logic           consume_i,
  input  logic [kdhr_pkg::KeyW-1:0] consume_key_i,
  input  logic           take_i,
  input  logic           flush_i,
  input  logic           tok_i,
  input  logic           rest_i,
  output logic           tok_o,
  output logic           rest_o,
  output kdhr_pkg::head_t head_o
);
  import kdhr_pkg::*;

  localparam logic [KeyW-1:0] KeyLow = KeyW'(KEY_IDX % 8);

  logic             raw_q, raw_d;
  logic [TimeW-1:0] raw_t_q, raw_t_d;
  logic             deb_q, deb_d;
  logic [TimeW-1:0] press_t_q, press_t_d;
  logic             hs_q, hs_d;
  logic [TimeW-1:0] lrt_q, lrt_d;
  logic             lock_q, lock_d;
  logic [NumSlots-1:0] pend_q, pend_d;
  logic             up_held_q, up_held_d;
  logic             tok_q, tok_d;

  logic             raw_lv, press, rel, hold, rpt, deb1, hs0;
  logic [TimeW-1:0] raw_t, press_t1;
  logic [TimeW-1:0] dt_raw, dt_press, dt_rpt;
  logic [NumSlots-1:0] new_pend, lowest;
  logic             pass;

  always_comb begin
    raw_lv   = scan_i.sample ? port_bit_i : raw_q;
    raw_t    = scan_i.sample ? scan_i.stime : raw_t_q;
    dt_raw   = scan_i.now - raw_t;
    press    = raw_lv && !deb_q;
    rel      = !raw_lv && deb_q && (dt_raw >= TimeW'(cfg_i.debounce));
    deb1     = press || (deb_q && !rel);
    press_t1 = press ? raw_t : press_t_q;
    hs0      = press ? 1'b0 : hs_q;
    dt_press = scan_i.now - press_t1;
    dt_rpt   = scan_i.now - lrt_q;
    hold     = deb1 && !hs0 && (dt_press >= TimeW'(cfg_i.hold_dly));
    rpt      = deb1 && (dt_press >= TimeW'(cfg_i.rpt_dly)) &&
               (dt_rpt >= TimeW'(cfg_i.rpt_intvl));

    // A locked key stays silent except for down and press.
    new_pend             = '0;
    new_pend[SlotDown]   = press;
    new_pend[SlotPress]  = press;
    new_pend[SlotUp]     = rel && !lock_q;
    new_pend[SlotHold]   = hold && !lock_q;
    new_pend[SlotRepeat] = rpt && !lock_q;
  end

  assign lowest = pend_q & (~pend_q + NumSlots'(1));
  assign pass   = tok_q && ((pend_q == '0) || (take_i && (pend_q == lowest)));

  always_comb begin
    raw_d     = raw_q;
    raw_t_d   = raw_t_q;
    deb_d     = deb_q;
    press_t_d = press_t_q;
    hs_d      = hs_q;
    lrt_d     = lrt_q;
    lock_d    = lock_q;
    pend_d    = pend_q;
    up_held_d = up_held_q;
    if (scan_i.start) begin
      raw_d     = raw_lv;
      raw_t_d   = raw_t;
      deb_d     = deb1;
      press_t_d = press_t1;
      hs_d      = hs0 || hold;
      lrt_d     = rpt ? scan_i.now : lrt_q;
      lock_d    = rel ? 1'b0 : lock_q;
      pend_d    = new_pend;
      up_held_d = hs_q;
    end else if (flush_i) begin
      pend_d = '0;
    end else if (take_i && tok_q) begin
      pend_d = pend_q & ~lowest;
    end
    if (consume_i && (KEY_IDX < 8) && (consume_key_i == KeyLow)) begin
      lock_d = 1'b1;
    end
    tok_d = flush_i ? 1'b0 : (tok_i || (tok_q && !pass));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q     <= 1'b0;
      raw_t_q   <= '0;
      deb_q     <= 1'b0;
      press_t_q <= '0;
      hs_q      <= 1'b0;
      lrt_q     <= '0;
      lock_q    <= 1'b0;
      pend_q    <= '0;
      up_held_q <= 1'b0;
      tok_q     <= 1'b0;
    end else begin
      raw_q     <= raw_d;
      raw_t_q   <= raw_t_d;
      deb_q     <= deb_d;
      press_t_q <= press_t_d;
      hs_q      <= hs_d;
      lrt_q     <= lrt_d;
      lock_q    <= lock_d;
      pend_q    <= pend_d;
      up_held_q <= up_held_d;
      tok_q     <= tok_d;
    end
  end

  assign tok_o  = pass && !flush_i;
  assign rest_o = (pend_q != '0) || rest_i;

  always_comb begin
    head_o              = '0;
    head_o.valid        = tok_q && (pend_q != '0);
    head_o.key          = head_o.valid ? KeyLow : '0;
    head_o.last_in_cell = head_o.valid && (pend_q == lowest);
    head_o.rest_after   = head_o.valid && rest_i;
    if (!head_o.valid) begin
      head_o.kind = KindDown;
    end else if (lowest[SlotDown]) begin
      head_o.kind = KindDown;
    end else if (lowest[SlotPress]) begin
      head_o.kind = KindPress;
    end else if (lowest[SlotUp]) begin
      head_o.kind = up_held_q ? KindUpHeld : KindUp;
    end else if (lowest[SlotHold]) begin
      head_o.kind = KindHold;
    end else begin
      head_o.kind = KindRepeat;
    end
  end

endmodule

@@ rtl/key_event_debounce_hold_repeat.sv @@
// Top level of the key event debounce, hold and repeat block.
//
// Usage: one input beat on the s_axis channel either samples the port levels
// and scans every key, scans only, or locks out one key (tuser selects which).
// Every key has a cell of its own; a scan updates all cells together and
// then passes an emission token down the row of cells, key 0 first. The cell
// holding the token hands out its pending events one per cycle on m_axis
// when not stalled; a cell with nothing pending gives the token on.
// A scan yields at most 32 beats; the final beat of a scan carries tlast. A
// consume or an unused action yields nothing. The output register lets the
// next input beat in while the final event still waits; a stalled receiver
// holds the token in place.
// Configuration writes are accepted at any time, meant while the block idles.
// Reset clears all key state and loads the default timing registers.
`timescale 1ns / 1ps
module key_event_debounce_hold_repeat #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [kdhr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kdhr_pkg::TickW-1:0]   cfg_data_i,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] port_bits, [39:8] sample_time, [71:40] now_time, [74:72] key_index
  input  logic [79:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] event_key
  output logic [7:0]  m_axis_tdata,
  // [2:0] event_kind
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import kdhr_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ov_q, ov_d;
  logic [KeyW-1:0]  okey_q, okey_d;
  kind_e            okind_q, okind_d;
  logic             olast_q, olast_d;

  logic [PortW-1:0] port_bits;
  logic [TimeW-1:0] sample_time, now_time;
  logic [KeyW-1:0]  key_index;
  action_e          action;
  logic             in_acc, consume, take, flush, last;
  scan_t            scan;
  head_t            head;
  head_t            heads [NUM_KEYS];
  logic [NUM_KEYS:0] tok, rest;
  logic [$bits(head_t)-1:0] head_acc;

  assign port_bits   = s_axis_tdata[7:0];
  assign sample_time = s_axis_tdata[39:8];
  assign now_time    = s_axis_tdata[71:40];
  assign key_index   = s_axis_tdata[74:72];
  assign action      = action_e'(s_axis_tuser);

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Decode the action of an accepted beat.
  always_comb begin
    scan       = '0;
    consume    = 1'b0;
    scan.stime = sample_time;
    scan.now   = now_time;
    if (in_acc) begin
      case (action)
        ActSample: begin
          scan.start  = 1'b1;
          scan.sample = 1'b1;
        end
        ActScan: begin
          scan.start = 1'b1;
        end
        ActConsume: begin
          consume = 1'b1;
        end
        default: begin
          scan.start = 1'b0;
        end
      endcase
    end
  end

  // Cell row: the token enters at key 0, the pending flag ripples back.
  assign tok[0]         = scan.start;
  assign rest[NUM_KEYS] = 1'b0;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
    logic port_bit;
    if (k < PortW) begin : g_port
      assign port_bit = port_bits[k];
    end else begin : g_none
      assign port_bit = 1'b0;
    end
    kdhr_cell #(
      .KEY_IDX(k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cfg_i        (cfg_q),
      .scan_i       (scan),
      .port_bit_i   (port_bit),
      .consume_i    (consume),
      .consume_key_i(key_index),
      .take_i       (take),
      .flush_i      (flush),
      .tok_i        (tok[k]),
      .rest_i       (rest[k+1]),
      .tok_o        (tok[k+1]),
      .rest_o       (rest[k]),
      .head_o       (heads[k])
    );
  end

  // Only the token holder drives a nonzero head.
  always_comb begin
    head_acc = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      head_acc = head_acc | heads[k];
    end
    head = head_t'(head_acc);
  end

  // Move a head event into the output register when it is free or draining.
  assign take  = head.valid && (!ov_q || m_axis_tready);
  assign last  = (cnt_q == CntW'(MaxResults - 1)) ||
                 (head.last_in_cell && !head.rest_after);
  assign flush = take && last;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q;
    okey_d  = okey_q;
    okind_d = okind_q;
    olast_d = olast_q;
    if (scan.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (flush || tok[NUM_KEYS]) begin
      busy_d = 1'b0;
    end
    if (take) begin
      cnt_d = cnt_q + CntW'(1);
    end
    if (take) begin
      ov_d    = 1'b1;
      okey_d  = head.key;
      okind_d = head.kind;
      olast_d = last;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  // Timing registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDebounce: cfg_d.debounce  = cfg_data_i;
        CfgHold:     cfg_d.hold_dly  = cfg_data_i;
        CfgRptDelay: cfg_d.rpt_dly   = cfg_data_i;
        CfgRptIntvl: cfg_d.rpt_intvl = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce  <= TickW'(2);
      cfg_q.hold_dly  <= TickW'(50);
      cfg_q.rpt_dly   <= TickW'(50);
      cfg_q.rpt_intvl <= TickW'(10);
      busy_q          <= 1'b0;
      cnt_q           <= '0;
      ov_q            <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okey_q  <= okey_d;
    okind_q <= okind_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'b0, okey_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule
